[rtl/core/dblpwm_pkg.sv]
`timescale 1ns / 1ps

package dblpwm_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_INTERVAL_DEF = 4;
  localparam int CHANNELS_DEF = 4;

  // Only channels 0 to 3 reach the led_on field.
  localparam int LED_BITS = 4;
  localparam int CFG_DATA_W = 2;

  // Command codes carried in the cmd field.
  typedef enum logic [1:0] {
    CMD_TICK         = 2'd0,
    CMD_WRITE        = 2'd1,
    CMD_ALL_OFF      = 2'd2,
    CMD_SAMPLE_TAKEN = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SHARED_MODE = 1'b0,
    CFG_SHARED_CHAN = 1'b1
  } cfg_idx_t;

  // One input transaction.
  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] led_index;
    logic [7:0] brightness;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [LED_BITS-1:0] led_on;
    logic                shared_pin_input;
    logic                sample_ready;
    logic [7:0]          phase;
  } out_item_t;

endpackage

[rtl/core/dblpwm_core.sv]
`timescale 1ns / 1ps

module dblpwm_core #(
  parameter int SAMPLE_INTERVAL = dblpwm_pkg::SAMPLE_INTERVAL_DEF,
  parameter int CHANNELS = dblpwm_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  dblpwm_pkg::in_item_t                item,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [dblpwm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dblpwm_pkg::out_item_t               result
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW = (SAMPLE_INTERVAL > 1) ? $clog2(SAMPLE_INTERVAL) : 1;
  localparam int LVL = (CHANNELS < dblpwm_pkg::LED_BITS) ? CHANNELS : dblpwm_pkg::LED_BITS;

  // Configuration registers.
  logic       shared_mode;
  logic [1:0] shared_chan;

  // PWM state.
  logic [7:0]                        phase;
  logic [MW-1:0]                     phase_mod;
  logic [7:0]                        active_duty [CHANNELS];
  logic [7:0]                        pending_duty [CHANNELS];
  logic                              swap_pending;
  logic                              pin_is_input;
  logic                              ready_flag;
  logic [dblpwm_pkg::LED_BITS-1:0]   pin_levels;

  logic [7:0]                        phase_next;
  logic [MW-1:0]                     phase_mod_next;
  logic [7:0]                        active_duty_next [CHANNELS];
  logic [7:0]                        pending_duty_next [CHANNELS];
  logic                              swap_pending_next;
  logic                              pin_is_input_next;
  logic                              ready_flag_next;
  logic [dblpwm_pkg::LED_BITS-1:0]   pin_levels_next;

  logic [MW:0]  mod_inc;
  logic         mod_wrap;
  logic         shared_ok;
  logic [2:0]   shared_ext;
  logic [7:0]   shared_duty;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_mode <= 1'b1;
      shared_chan <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dblpwm_pkg::CFG_SHARED_MODE: shared_mode <= cfg_data[0];
        dblpwm_pkg::CFG_SHARED_CHAN: shared_chan <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase modulo the sample interval, tracked alongside the phase counter.
  assign mod_inc  = {1'b0, phase_mod} + (MW+1)'(1);
  assign mod_wrap = (mod_inc == (MW+1)'(SAMPLE_INTERVAL));

  assign shared_ext = {1'b0, shared_chan};
  assign shared_ok  = shared_mode && ({2'b00, shared_chan} < 4'(CHANNELS));
  assign shared_duty = active_duty_next[shared_ext[CW-1:0]];

  // Next-state logic for one transaction.
  always_comb begin
    phase_next        = phase;
    phase_mod_next    = phase_mod;
    active_duty_next  = active_duty;
    pending_duty_next = pending_duty;
    swap_pending_next = swap_pending;
    pin_is_input_next = pin_is_input;
    ready_flag_next   = ready_flag;
    pin_levels_next   = pin_levels;
    case (item.cmd)
      dblpwm_pkg::CMD_TICK: begin
        phase_next = phase + 8'd1;
        phase_mod_next = (phase_next == 8'd0 || mod_wrap) ? '0 : mod_inc[MW-1:0];
        if (phase_next == 8'd0 && swap_pending) begin
          active_duty_next  = pending_duty;
          swap_pending_next = 1'b0;
        end
        if (shared_ok && (phase_next > shared_duty)) begin
          pin_is_input_next = 1'b1;
          if (phase_mod_next == '0) begin
            ready_flag_next = 1'b1;
          end
        end else begin
          pin_is_input_next = 1'b0;
          ready_flag_next   = 1'b0;
        end
        pin_levels_next = '0;
        for (int ch = 0; ch < LVL; ch++) begin
          pin_levels_next[ch] = (active_duty_next[ch] > phase_next);
        end
      end
      dblpwm_pkg::CMD_WRITE: begin
        if ({1'b0, item.led_index} < 4'(CHANNELS)) begin
          pending_duty_next[item.led_index[CW-1:0]] = item.brightness;
          swap_pending_next = 1'b1;
        end
      end
      dblpwm_pkg::CMD_ALL_OFF: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          active_duty_next[ch]  = 8'd0;
          pending_duty_next[ch] = 8'd0;
        end
        swap_pending_next = 1'b0;
        pin_levels_next   = '0;
      end
      dblpwm_pkg::CMD_SAMPLE_TAKEN: begin
        ready_flag_next = 1'b0;
      end
      default: ;
    endcase
  end

  // State registers update once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 8'd0;
      phase_mod    <= '0;
      swap_pending <= 1'b0;
      pin_is_input <= 1'b0;
      ready_flag   <= 1'b0;
      pin_levels   <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        active_duty[ch]  <= 8'd0;
        pending_duty[ch] <= 8'd0;
      end
    end else if (fire) begin
      phase        <= phase_next;
      phase_mod    <= phase_mod_next;
      swap_pending <= swap_pending_next;
      pin_is_input <= pin_is_input_next;
      ready_flag   <= ready_flag_next;
      pin_levels   <= pin_levels_next;
      active_duty  <= active_duty_next;
      pending_duty <= pending_duty_next;
    end
  end

  // The result reflects the state after the transaction.
  assign result.led_on           = pin_levels_next;
  assign result.shared_pin_input = pin_is_input_next;
  assign result.sample_ready     = ready_flag_next;
  assign result.phase            = phase_next;

endmodule

[rtl/core/double_buffered_led_pwm_top.sv]
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register goes through the core's state
// update into the result register and waits there until taken; result_stall holds it.
// Throughput: one transaction per cycle while result_stall is low; the state update is
// a single registered step between the input register and the result register.
// Reset (rst, synchronous, active high) clears the phase, both duty buffers, the swap
// request, the pin state and the handshake registers; sharing starts on channel 1.

module double_buffered_led_pwm_top #(
  parameter int SAMPLE_INTERVAL = dblpwm_pkg::SAMPLE_INTERVAL_DEF,
  parameter int CHANNELS = dblpwm_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  dblpwm_pkg::in_item_t               item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output dblpwm_pkg::out_item_t              result,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [dblpwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dblpwm_pkg::in_item_t  in_reg;
  logic                  in_reg_valid;
  dblpwm_pkg::out_item_t core_result;
  logic                  advance;
  logic                  fire;

  // The pipeline moves when the result register is empty or being taken.
  assign advance    = !result_valid || !result_stall;
  assign fire       = in_reg_valid && advance;
  assign item_stall = in_reg_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!item_stall) begin
      in_reg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_reg <= item;
    end
  end

  dblpwm_core #(
    .SAMPLE_INTERVAL(SAMPLE_INTERVAL),
    .CHANNELS(CHANNELS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .item(in_reg),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result(core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

  // A stall on the input side only happens with a transaction held.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_reg_valid)
    else $error("input stalled with empty input register");

  // A held transaction is not altered while stalled.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> in_reg_valid && $stable(in_reg))
    else $error("held input transaction changed");

  // Only a tick moves the phase.
  a_phase_tick: assert property (@(posedge clk) disable iff (rst)
    (fire && result_valid && in_reg.cmd != dblpwm_pkg::CMD_TICK) |=>
      result.phase == $past(result.phase))
    else $error("phase moved on a non-tick command");

  // All off drives every pin low at once.
  a_all_off: assert property (@(posedge clk) disable iff (rst)
    (fire && in_reg.cmd == dblpwm_pkg::CMD_ALL_OFF) |=> result.led_on == '0)
    else $error("pins not cleared by all off");

  // The sample flag is only raised while the shared pin is an input.
  a_ready_input: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.sample_ready || result.shared_pin_input))
    else $error("sample ready while shared pin is an output");

endmodule

[verif/double_buffered_led_pwm_top_tb.sv]
`timescale 1ns / 1ps

module double_buffered_led_pwm_top_tb;
  import dblpwm_pkg::*;

  localparam int SAMPLE_INTERVAL = SAMPLE_INTERVAL_DEF;
  localparam int CHANNELS = CHANNELS_DEF;
  localparam int RANDOM_PER_PHASE = 360;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;
  // Sharing mode and shared channel for each configuration phase, phase 0 in the lowest bits.
  localparam logic [4:0] MODE_SEQ = 5'b11101;
  localparam logic [9:0] CHAN_SEQ = {2'd2, 2'd1, 2'd3, 2'd3, 2'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Commands waiting to be offered, and PWM outputs waiting to be seen.
  in_item_t cmd_queue[$];
  out_item_t expected_pwm[$];
  int mismatch_count = 0;

  // Handshake between the stimulus sequence and the idling processes.
  int hold_off_requests = 0;
  int hold_off_served = 0;
  bit quiet_tail = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // Predicted copy of the PWM state and its configuration.
  logic [7:0] pwm_phase;
  logic [7:0] duty_active [CHANNELS];
  logic [7:0] duty_pending [CHANNELS];
  logic swap_req;
  logic pin_input;
  logic ready;
  logic [3:0] levels;
  logic share_mode;
  logic [1:0] share_chan;

  double_buffered_led_pwm_top u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the predicted state by one command and return the outputs after it.
  function automatic out_item_t step_pwm(in_item_t it);
    out_item_t o;
    case (it.cmd)
      CMD_TICK: begin
        pwm_phase = pwm_phase + 8'd1;
        if (pwm_phase == 8'd0 && swap_req) begin
          duty_active = duty_pending;
          swap_req = 1'b0;
        end
        if (share_mode && int'(share_chan) < CHANNELS) begin
          if (pwm_phase > duty_active[share_chan]) begin
            pin_input = 1'b1;
            if ((int'(pwm_phase) % SAMPLE_INTERVAL) == 0) ready = 1'b1;
          end else begin
            pin_input = 1'b0;
            ready = 1'b0;
          end
        end else begin
          pin_input = 1'b0;
          ready = 1'b0;
        end
        levels = '0;
        for (int ch = 0; ch < CHANNELS && ch < 4; ch++) begin
          if (duty_active[ch] > pwm_phase) levels[ch] = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (int'(it.led_index) < CHANNELS) begin
          duty_pending[it.led_index] = it.brightness;
          swap_req = 1'b1;
        end
      end
      CMD_ALL_OFF: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          duty_active[ch] = '0;
          duty_pending[ch] = '0;
        end
        swap_req = 1'b0;
        levels = '0;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
    o.led_on = levels;
    o.shared_pin_input = pin_input;
    o.sample_ready = ready;
    o.phase = pwm_phase;
    return o;
  endfunction

  // Compare one observed result with its prediction, field by field.
  function automatic void check_result(out_item_t want, out_item_t got);
    if (got.led_on !== want.led_on) begin
      mismatch_count++;
      $display("%0t: led_on expected %h actual %h", $time, want.led_on, got.led_on);
    end
    if (got.shared_pin_input !== want.shared_pin_input) begin
      mismatch_count++;
      $display("%0t: shared_pin_input expected %b actual %b", $time,
               want.shared_pin_input, got.shared_pin_input);
    end
    if (got.sample_ready !== want.sample_ready) begin
      mismatch_count++;
      $display("%0t: sample_ready expected %b actual %b", $time,
               want.sample_ready, got.sample_ready);
    end
    if (got.phase !== want.phase) begin
      mismatch_count++;
      $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
    end
  endfunction

  // Random command, weighted toward ticks so the phase wraps several times.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 68) it.cmd = CMD_TICK;
    else if (pick < 85) it.cmd = CMD_WRITE;
    else if (pick < 88) it.cmd = CMD_ALL_OFF;
    else it.cmd = CMD_SAMPLE_TAKEN;
    if ($urandom_range(0, 4) == 0) it.led_index = 3'($urandom_range(4, 7));
    else it.led_index = 3'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.brightness = 8'd0;
    else if (pick == 1) it.brightness = 8'd255;
    else it.brightness = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void queue_cmd(cmd_t c, logic [2:0] idx, logic [7:0] val);
    in_item_t it;
    it.cmd = c;
    it.led_index = idx;
    it.brightness = val;
    cmd_queue.push_back(it);
  endfunction

  // Write one register while the block is idle and mirror it in the prediction.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHARED_MODE: share_mode = val[0];
      default: share_chan = val[1:0];
    endcase
  endtask

  // Hold further stimulus until every expected result has come back.
  // The check runs on the falling edge, once the rising-edge updates have settled.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || item_valid || expected_pwm.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Stimulus sequence: reset, then one configuration phase after another.
  initial begin
    pwm_phase = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      duty_active[ch] = '0;
      duty_pending[ch] = '0;
    end
    swap_req = 1'b0;
    pin_input = 1'b0;
    ready = 1'b0;
    levels = '0;
    share_mode = 1'b1;
    share_chan = 2'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 5; p++) begin
      if (p == 4) quiet_tail = 1'b1;
      write_reg(CFG_SHARED_MODE, {1'b0, MODE_SEQ[p]});
      write_reg(CFG_SHARED_CHAN, CHAN_SEQ[2*p +: 2]);
      if (p == 0) begin
        // Extremes of every field, ignored channels, all off and acknowledge.
        queue_cmd(CMD_WRITE, 3'd0, 8'd255);
        queue_cmd(CMD_WRITE, 3'd1, 8'd0);
        queue_cmd(CMD_WRITE, 3'd2, 8'h55);
        queue_cmd(CMD_WRITE, 3'd3, 8'hAA);
        queue_cmd(CMD_WRITE, 3'd4, 8'd77);
        queue_cmd(CMD_WRITE, 3'd7, 8'd255);
        queue_cmd(CMD_TICK, 3'd7, 8'hFF);
        queue_cmd(CMD_TICK, 3'd0, 8'd0);
        queue_cmd(CMD_TICK, 3'd5, 8'd1);
        queue_cmd(CMD_TICK, 3'd2, 8'd3);
        queue_cmd(CMD_SAMPLE_TAKEN, 3'd6, 8'hF0);
        queue_cmd(CMD_TICK, 3'd1, 8'd9);
        queue_cmd(CMD_ALL_OFF, 3'd3, 8'h0F);
        queue_cmd(CMD_TICK, 3'd0, 8'd0);
        queue_cmd(CMD_WRITE, 3'd0, 8'd1);
        queue_cmd(CMD_WRITE, 3'd1, 8'd254);
        queue_cmd(CMD_ALL_OFF, 3'd0, 8'd0);
        queue_cmd(CMD_TICK, 3'd0, 8'd0);
        queue_cmd(CMD_SAMPLE_TAKEN, 3'd0, 8'd0);
        queue_cmd(CMD_TICK, 3'd4, 8'd128);
        // The receiver holds off for a long stretch while commands keep coming.
        hold_off_requests++;
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) cmd_queue.push_back(random_cmd());
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pwm.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Command driver: offers queued commands, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!(item_valid && item_stall)) begin
      if (send_gap == 0 && !quiet_tail && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 18);
      end
      if (send_gap != 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        item <= cmd_queue.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result stall: random bursts, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_off_served != hold_off_requests) begin
        hold_off_served++;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left != 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts each accepted command and checks each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) expected_pwm.push_back(step_pwm(item));
      if (result_valid && !result_stall) begin
        if (expected_pwm.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing actual %h",
                   $time, result);
        end else begin
          check_result(expected_pwm.pop_front(), result);
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/core/dblpwm_pkg.sv
rtl/core/dblpwm_core.sv
rtl/core/double_buffered_led_pwm_top.sv
verif/double_buffered_led_pwm_top_tb.sv
